// File: design/velocity_pid_controller_top_defines.svh
// Assertion macros for the velocity PID controller.
`ifndef VELOCITY_PID_CONTROLLER_TOP_DEFINES_SVH
`define VELOCITY_PID_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VPT_ASSERT_IMPL(lbl, ante, cons, msg)
`define VPT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/vpid_pkg.sv
// Shared types and constants for the velocity PID controller.
package vpid_pkg;

  localparam int DATA_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_PROD  = 6;

  // product slots
  localparam int P_KP_E   = 0;
  localparam int P_KI_E   = 1;
  localparam int P_KP_EP  = 2;
  localparam int P_KD_X   = 3;
  localparam int P_KD_XP  = 4;
  localparam int P_KD_XPP = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = word_t'({1'b1, {(DATA_W-1){1'b0}}});
  localparam word_t WORD_MAX = word_t'({1'b0, {(DATA_W-1){1'b1}}});

  typedef enum logic [1:0] {
    FUNC_STEP     = 2'd0,
    FUNC_ERR_ONLY = 2'd1,
    FUNC_RESET    = 2'd2,
    FUNC_HOLD     = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P = 2'd0,
    CFG_GAIN_I = 2'd1,
    CFG_GAIN_D = 2'd2,
    CFG_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    word_t kp;
    word_t ki;
    word_t kd;
  } gains_t;

  typedef struct packed {
    func_t func;
    word_t err;
    word_t plant;
    word_t err_prev;
    word_t plant_prev;
    word_t plant_prev2;
  } operands_t;

endpackage

// File: design/velocity_pid_controller_top.sv
// Top level of the velocity-form PID controller.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------
//  cfg       in         cfg_we               cfg_index, cfg_data
//  in        in         in_valid / in_stall  func, error_value, plant_value
//  out       out        out_valid/out_stall  drive
//
// One request per cycle sustained while out_stall is low. Four registers in line
// (input/history, gain multiply, increment adder, clamped drive); out_valid
// rises once a taken request has passed through all four. Drive feedback closes in the
// last stage (one add plus clamp). Synchronous reset clears gains, limit,
// history, drive and all stage valids. Stalls back up stage by stage;
// in_stall rises only when all four stages hold and out_stall is high.
`include "velocity_pid_controller_top_defines.svh"

module velocity_pid_controller_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpid_pkg::DATA_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic signed [vpid_pkg::DATA_W-1:0] error_value,
  input  logic signed [vpid_pkg::DATA_W-1:0] plant_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [vpid_pkg::DATA_W-1:0] drive
);
  import vpid_pkg::*;

  localparam int PW = 2 * DATA_W - FRAC_BITS;
  localparam int IW = PW + 3;

  // configuration registers
  gains_t               gains;
  logic [LIMIT_W-1:0]   limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
      limit <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P: gains.kp <= word_t'(cfg_data);
        CFG_GAIN_I: gains.ki <= word_t'(cfg_data);
        CFG_GAIN_D: gains.kd <= word_t'(cfg_data);
        CFG_LIMIT:  limit    <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage handshakes: each ready looks one stage ahead
  logic      s1_ready, s1_valid;
  logic      s2_ready, s2_valid;
  logic      s3_ready, s3_valid;
  logic      s4_ready;
  operands_t ops;
  func_t     s2_func, s3_func;
  logic signed [PW-1:0] prod [NUM_PROD];
  logic signed [IW-1:0] inc;
  word_t     drive_q;

  assign in_stall = !s1_ready;
  assign drive    = drive_q;

  vpid_hist u_hist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .ready      (s1_ready),
    .func       (func_t'(func)),
    .err        (error_value),
    .plant      (plant_value),
    .valid      (s1_valid),
    .next_ready (s2_ready),
    .ops        (ops)
  );

  vpid_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .ready      (s2_ready),
    .gains      (gains),
    .ops        (ops),
    .valid      (s2_valid),
    .next_ready (s3_ready),
    .func       (s2_func),
    .prod       (prod)
  );

  vpid_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .ready      (s3_ready),
    .in_func    (s2_func),
    .prod       (prod),
    .valid      (s3_valid),
    .next_ready (s4_ready),
    .func       (s3_func),
    .inc        (inc)
  );

  vpid_drive #(.FRAC_BITS(FRAC_BITS)) u_drive (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s3_valid),
    .ready      (s4_ready),
    .func       (s3_func),
    .inc        (inc),
    .limit      (limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive      (drive_q)
  );

  // checks
  logic [3:0] inflight;
  logic       in_take, out_take;

  assign inflight = {s1_valid, s2_valid, s3_valid, out_valid};
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  `VPT_ASSERT_IMPL(a_stall_only_when_full, in_stall, inflight == 4'b1111, "in_stall while a stage is empty")
  `VPT_ASSERT_IMPL(a_request_count, !$past(rst), $countones(inflight) == $countones($past(inflight)) + $past(in_take) - $past(out_take), "request lost or duplicated in pipeline")
  `VPT_ASSERT_NEXT(a_sum_to_drive, s3_valid && s4_ready, out_valid, "increment not moved into drive stage")

endmodule

// File: design/vpid_hist.sv
// Input register and error / plant history.
module vpid_hist (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              ready,
  input  vpid_pkg::func_t   func,
  input  vpid_pkg::word_t   err,
  input  vpid_pkg::word_t   plant,
  output logic              valid,
  input  logic              next_ready,
  output vpid_pkg::operands_t ops
);
  import vpid_pkg::*;

  word_t last_error, last_error_next;
  word_t plant_last, plant_last_next;
  word_t plant_before, plant_before_next;
  word_t plant_eff;
  logic  load;

  assign ready = !valid || next_ready;
  assign load  = in_valid && ready;

  always_comb begin
    if (func == FUNC_ERR_ONLY) begin
      plant_eff = (err == WORD_MIN) ? WORD_MAX : -err;
    end else begin
      plant_eff = plant;
    end
  end

  always_comb begin
    last_error_next   = last_error;
    plant_last_next   = plant_last;
    plant_before_next = plant_before;
    case (func)
      FUNC_STEP, FUNC_ERR_ONLY: begin
        last_error_next   = err;
        plant_last_next   = plant_eff;
        plant_before_next = plant_last;
      end
      FUNC_RESET: begin
        last_error_next   = '0;
        plant_last_next   = plant;
        plant_before_next = plant;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      last_error   <= '0;
      plant_last   <= '0;
      plant_before <= '0;
    end else begin
      if (load) begin
        valid        <= 1'b1;
        last_error   <= last_error_next;
        plant_last   <= plant_last_next;
        plant_before <= plant_before_next;
      end else if (next_ready) begin
        valid <= 1'b0;
      end
    end
  end

  // operands see history as it was before this item
  always_ff @(posedge clk) begin
    if (load) begin
      ops.func        <= func;
      ops.err         <= err;
      ops.plant       <= plant_eff;
      ops.err_prev    <= last_error;
      ops.plant_prev  <= plant_last;
      ops.plant_prev2 <= plant_before;
    end
  end

endmodule

// File: design/vpid_mult.sv
// Six gain products, rescaled by an arithmetic shift.
module vpid_mult #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                ready,
  input  vpid_pkg::gains_t    gains,
  input  vpid_pkg::operands_t ops,
  output logic                valid,
  input  logic                next_ready,
  output vpid_pkg::func_t     func,
  output logic signed [2*vpid_pkg::DATA_W-FRAC_BITS-1:0] prod [vpid_pkg::NUM_PROD]
);
  import vpid_pkg::*;

  localparam int FULL_W = 2 * DATA_W;

  logic signed [FULL_W-1:0] full [NUM_PROD];
  logic                     load;

  assign ready = !valid || next_ready;
  assign load  = in_valid && ready;

  assign full[P_KP_E]   = gains.kp * ops.err;
  assign full[P_KI_E]   = gains.ki * ops.err;
  assign full[P_KP_EP]  = gains.kp * ops.err_prev;
  assign full[P_KD_X]   = gains.kd * ops.plant;
  assign full[P_KD_XP]  = gains.kd * ops.plant_prev;
  assign full[P_KD_XPP] = gains.kd * ops.plant_prev2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (next_ready) begin
      valid <= 1'b0;
    end
  end

  // dropping low bits of a signed value floors it
  always_ff @(posedge clk) begin
    if (load) begin
      func <= ops.func;
      for (int i = 0; i < NUM_PROD; i++) begin
        prod[i] <= full[i][FULL_W-1:FRAC_BITS];
      end
    end
  end

endmodule

// File: design/vpid_sum.sv
// Sums the scaled products into one drive increment.
module vpid_sum #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            ready,
  input  vpid_pkg::func_t in_func,
  input  logic signed [2*vpid_pkg::DATA_W-FRAC_BITS-1:0] prod [vpid_pkg::NUM_PROD],
  output logic            valid,
  input  logic            next_ready,
  output vpid_pkg::func_t func,
  output logic signed [2*vpid_pkg::DATA_W-FRAC_BITS+2:0] inc
);
  import vpid_pkg::*;

  localparam int PW = 2 * DATA_W - FRAC_BITS;
  localparam int IW = PW + 3;

  logic signed [IW-1:0] inc_next;
  logic                 load;

  assign ready = !valid || next_ready;
  assign load  = in_valid && ready;

  assign inc_next = IW'(prod[P_KP_E]) + IW'(prod[P_KI_E]) - IW'(prod[P_KP_EP])
                  - IW'(prod[P_KD_X]) + (IW'(prod[P_KD_XP]) <<< 1)
                  - IW'(prod[P_KD_XPP]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (next_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      func <= in_func;
      inc  <= inc_next;
    end
  end

endmodule

// File: design/vpid_drive.sv
// Drive accumulator with symmetric clamp; also the result register.
module vpid_drive #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           ready,
  input  vpid_pkg::func_t                func,
  input  logic signed [2*vpid_pkg::DATA_W-FRAC_BITS+2:0] inc,
  input  logic [vpid_pkg::LIMIT_W-1:0]   limit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vpid_pkg::word_t                drive
);
  import vpid_pkg::*;

  localparam int IW = 2 * DATA_W - FRAC_BITS + 3;
  localparam int AW = IW + 1;

  logic signed [AW-1:0] acc, lim, lim_neg;
  word_t                drive_next;
  logic                 load;

  assign ready = !out_valid || !out_stall;
  assign load  = in_valid && ready;

  assign acc     = AW'(drive) + AW'(inc);
  assign lim     = $signed(AW'(limit));
  assign lim_neg = -lim;

  always_comb begin
    case (func)
      FUNC_STEP, FUNC_ERR_ONLY: begin
        if (acc > lim) begin
          drive_next = word_t'(lim[DATA_W-1:0]);
        end else if (acc < lim_neg) begin
          drive_next = word_t'(lim_neg[DATA_W-1:0]);
        end else begin
          drive_next = word_t'(acc[DATA_W-1:0]);
        end
      end
      FUNC_RESET: drive_next = '0;
      default:    drive_next = drive;
    endcase
  end

  // drive is both the kept state and the output payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      drive     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      drive     <= drive_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
